/* rtl/core/indexed_list_table_top_macros.svh */
// ---------------------------------------------------------------------------
// Indexed list table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_TABLE_TOP_MACROS_SVH
`define INDEXED_LIST_TABLE_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ILT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ILT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/ilt_pkg.sv */
// ---------------------------------------------------------------------------
// Indexed list table package
// Command codes, status codes and the controller to datapath interface types.
// ---------------------------------------------------------------------------
package ilt_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 64;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESIZE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LD_COUNT,
        IDX_LD_POS,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_LD_TARGET
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_IDX_DEC,
        RD_IDX,
        RD_POS
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_COUNT,
        WA_IDX,
        WA_IDX_DEC,
        WA_POS
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_WORD,
        WD_RDATA,
        WD_ZERO
    } wd_sel_t;

    typedef struct packed {
        logic                load;
        idx_op_t             idx_op;
        cnt_op_t             cnt_op;
        rd_sel_t             rd_sel;
        logic                we;
        wa_sel_t             wa_sel;
        wd_sel_t             wd_sel;
        logic                fin;
        logic [STATUS_W-1:0] fin_status;
        logic                take_rdata;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_ok;
        logic             full;
        logic             target_big;
        logic             idx_ge_pos;
        logic             idx_lt_count;
        logic             idx_lt_target;
    } stat_t;

endpackage

/* rtl/core/indexed_list_table_top.sv */
// ---------------------------------------------------------------------------
// Indexed list table
// Ordered list of 64-bit words in a store of CAPACITY entries, edited by
// append, insert, replace, delete, resize and read commands.
// ---------------------------------------------------------------------------
// A command beat is taken on the rising edge where start is high and busy is
// low; cmd, position, word and new_count are sampled on that edge. One result
// beat follows per command: done is high for exactly one cycle while status,
// read_word and count hold the result, and it is taken on the edge ending
// that cycle. The receiver cannot hold results off and needs none.
// Busy drops in the done cycle, so the next command may start at that edge.
// Append, replace, unknown codes and any rejected command finish in decode,
// and read finishes after one store read. Insert and delete walk the moved
// entries, since each moved entry needs a store read and a store write
// through the registered read port of the entry memory. Resize writes one
// zero fill per cycle over the new entries when growing, and finishes
// without a fill otherwise.
// Reset empties the list at once; no clearing pass runs over the store.
// ---------------------------------------------------------------------------
module indexed_list_table_top #(
    parameter int CAPACITY = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ilt_pkg::CMD_W-1:0]       cmd,
    input  logic [ilt_pkg::POS_W-1:0]       position,
    input  logic [ilt_pkg::WORD_W-1:0]      word,
    input  logic [ilt_pkg::POS_W-1:0]       new_count,
    output logic                            done,
    output logic [ilt_pkg::STATUS_W-1:0]    status,
    output logic [ilt_pkg::WORD_W-1:0]      read_word,
    output logic [ilt_pkg::COUNT_W-1:0]     count
);

    ilt_pkg::ctrl_t ctrl;
    ilt_pkg::stat_t stat;

    ilt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    ilt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cmd       (cmd),
        .position  (position),
        .word      (word),
        .new_count (new_count),
        .done      (done),
        .status    (status),
        .read_word (read_word),
        .count     (count)
    );

endmodule

/* rtl/core/ilt_ctrl.sv */
// ---------------------------------------------------------------------------
// Indexed list table controller
// Sequences each command through decode and, as the command needs, shift, fill or read steps.
// ---------------------------------------------------------------------------
`include "indexed_list_table_top_macros.svh"

module ilt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ilt_pkg::stat_t stat,
    output ilt_pkg::ctrl_t ctrl
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_SHIFT_RD = 7'b0000100,
        S_SHIFT_WR = 7'b0001000,
        S_FILL     = 7'b0010000,
        S_READ     = 7'b0100000,
        S_SPARE    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ctrl.load       = 1'b0;
        ctrl.idx_op     = ilt_pkg::IDX_HOLD;
        ctrl.cnt_op     = ilt_pkg::CNT_HOLD;
        ctrl.rd_sel     = ilt_pkg::RD_POS;
        ctrl.we         = 1'b0;
        ctrl.wa_sel     = ilt_pkg::WA_POS;
        ctrl.wd_sel     = ilt_pkg::WD_WORD;
        ctrl.fin        = 1'b0;
        ctrl.fin_status = ilt_pkg::ST_DONE;
        ctrl.take_rdata = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                unique case (stat.cmd)
                    ilt_pkg::CMD_APPEND:
                    begin
                        ctrl.fin = 1'b1;
                        if (stat.full)
                        begin
                            ctrl.fin_status = ilt_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.we     = 1'b1;
                            ctrl.wa_sel = ilt_pkg::WA_COUNT;
                            ctrl.wd_sel = ilt_pkg::WD_WORD;
                            ctrl.cnt_op = ilt_pkg::CNT_INC;
                        end
                    end
                    ilt_pkg::CMD_INSERT:
                    begin
                        if (!stat.pos_ok)
                        begin
                            ctrl.fin        = 1'b1;
                            ctrl.fin_status = ilt_pkg::ST_BAD_POS;
                        end
                        else if (stat.full)
                        begin
                            ctrl.fin        = 1'b1;
                            ctrl.fin_status = ilt_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.idx_op = ilt_pkg::IDX_LD_COUNT;
                            state_next  = S_SHIFT_RD;
                        end
                    end
                    ilt_pkg::CMD_REPLACE:
                    begin
                        ctrl.fin = 1'b1;
                        if (!stat.pos_ok)
                        begin
                            ctrl.fin_status = ilt_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            ctrl.we     = 1'b1;
                            ctrl.wa_sel = ilt_pkg::WA_POS;
                            ctrl.wd_sel = ilt_pkg::WD_WORD;
                        end
                    end
                    ilt_pkg::CMD_DELETE:
                    begin
                        if (!stat.pos_ok)
                        begin
                            ctrl.fin        = 1'b1;
                            ctrl.fin_status = ilt_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            ctrl.idx_op = ilt_pkg::IDX_LD_POS;
                            state_next  = S_SHIFT_RD;
                        end
                    end
                    ilt_pkg::CMD_RESIZE:
                    begin
                        if (stat.target_big)
                        begin
                            ctrl.fin        = 1'b1;
                            ctrl.fin_status = ilt_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.idx_op = ilt_pkg::IDX_LD_COUNT;
                            state_next  = S_FILL;
                        end
                    end
                    ilt_pkg::CMD_READ:
                    begin
                        if (!stat.pos_ok)
                        begin
                            ctrl.fin        = 1'b1;
                            ctrl.fin_status = ilt_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            ctrl.rd_sel = ilt_pkg::RD_POS;
                            state_next  = S_READ;
                        end
                    end
                    default:
                    begin
                        ctrl.fin = 1'b1;
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                if (stat.cmd == ilt_pkg::CMD_INSERT)
                begin
                    if (stat.idx_ge_pos)
                    begin
                        ctrl.rd_sel = ilt_pkg::RD_IDX_DEC;
                        state_next  = S_SHIFT_WR;
                    end
                    else
                    begin
                        ctrl.we     = 1'b1;
                        ctrl.wa_sel = ilt_pkg::WA_POS;
                        ctrl.wd_sel = ilt_pkg::WD_WORD;
                        ctrl.cnt_op = ilt_pkg::CNT_INC;
                        ctrl.fin    = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    if (stat.idx_lt_count)
                    begin
                        ctrl.rd_sel = ilt_pkg::RD_IDX;
                        state_next  = S_SHIFT_WR;
                    end
                    else
                    begin
                        ctrl.cnt_op = ilt_pkg::CNT_DEC;
                        ctrl.fin    = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_SHIFT_WR:
            begin
                ctrl.we     = 1'b1;
                ctrl.wd_sel = ilt_pkg::WD_RDATA;
                if (stat.cmd == ilt_pkg::CMD_INSERT)
                begin
                    ctrl.wa_sel = ilt_pkg::WA_IDX;
                    ctrl.idx_op = ilt_pkg::IDX_DEC;
                end
                else
                begin
                    ctrl.wa_sel = ilt_pkg::WA_IDX_DEC;
                    ctrl.idx_op = ilt_pkg::IDX_INC;
                end
                state_next = S_SHIFT_RD;
            end
            S_FILL:
            begin
                if (stat.idx_lt_target)
                begin
                    ctrl.we     = 1'b1;
                    ctrl.wa_sel = ilt_pkg::WA_IDX;
                    ctrl.wd_sel = ilt_pkg::WD_ZERO;
                    ctrl.idx_op = ilt_pkg::IDX_INC;
                end
                else
                begin
                    ctrl.cnt_op = ilt_pkg::CNT_LD_TARGET;
                    ctrl.fin    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_READ:
            begin
                ctrl.take_rdata = 1'b1;
                ctrl.fin        = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ILT_ASSERT_NEXT(a_start_decodes, start && !busy, state_reg == S_DECODE,
        "Accepted command did not enter decode.")
    `ILT_ASSERT(a_write_after_read, (state_reg == S_SHIFT_WR) |-> ($past(state_reg) == S_SHIFT_RD),
        "Shift write without a preceding shift read.")
    `ILT_ASSERT_NEXT(a_fin_idles, ctrl.fin, state_reg == S_IDLE,
        "Controller did not return to idle after finishing a command.")

endmodule

/* rtl/core/ilt_datapath.sv */
// ---------------------------------------------------------------------------
// Indexed list table datapath
// Entry store, entry count, walk index, command capture and result registers.
// ---------------------------------------------------------------------------
`include "indexed_list_table_top_macros.svh"

module ilt_datapath #(
    parameter int CAPACITY = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ilt_pkg::ctrl_t                  ctrl,
    output ilt_pkg::stat_t                  stat,
    input  logic [ilt_pkg::CMD_W-1:0]       cmd,
    input  logic [ilt_pkg::POS_W-1:0]       position,
    input  logic [ilt_pkg::WORD_W-1:0]      word,
    input  logic [ilt_pkg::POS_W-1:0]       new_count,
    output logic                            done,
    output logic [ilt_pkg::STATUS_W-1:0]    status,
    output logic [ilt_pkg::WORD_W-1:0]      read_word,
    output logic [ilt_pkg::COUNT_W-1:0]     count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = (CW > ilt_pkg::POS_W) ? CW : ilt_pkg::POS_W;

    logic [ilt_pkg::WORD_W-1:0] mem [CAPACITY];

    logic [ilt_pkg::CMD_W-1:0]    cmd_reg;
    logic [ilt_pkg::POS_W-1:0]    pos_reg;
    logic [ilt_pkg::WORD_W-1:0]   word_reg;
    logic [ilt_pkg::POS_W-1:0]    target_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                idx_next;
    logic [ilt_pkg::WORD_W-1:0]   rdata_reg;
    logic                         done_reg;
    logic [ilt_pkg::STATUS_W-1:0] status_reg;
    logic [ilt_pkg::WORD_W-1:0]   read_word_reg;

    logic [EW-1:0]                pos_ext;
    logic [EW-1:0]                cnt_ext;
    logic [EW-1:0]                idx_ext;
    logic [EW-1:0]                tgt_ext;
    logic [AW-1:0]                pos_addr;
    logic [AW-1:0]                idx_addr;
    logic [AW-1:0]                idx_dec_addr;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic [ilt_pkg::WORD_W-1:0]   wr_data;

    assign pos_ext      = EW'(pos_reg);
    assign cnt_ext      = EW'(count_reg);
    assign idx_ext      = EW'(idx_reg);
    assign tgt_ext      = EW'(target_reg);
    assign pos_addr     = AW'(pos_ext - EW'(1));
    assign idx_addr     = idx_reg[AW-1:0];
    assign idx_dec_addr = AW'(idx_reg - CW'(1));

    assign stat.cmd           = cmd_reg;
    assign stat.pos_ok        = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign stat.full          = (count_reg == CW'(CAPACITY));
    assign stat.target_big    = (tgt_ext > EW'(CAPACITY));
    assign stat.idx_ge_pos    = (idx_ext >= pos_ext);
    assign stat.idx_lt_count  = (idx_reg < count_reg);
    assign stat.idx_lt_target = (idx_ext < tgt_ext);

    always_comb
    begin
        case (ctrl.rd_sel)
            ilt_pkg::RD_IDX_DEC: rd_addr = idx_dec_addr;
            ilt_pkg::RD_IDX:     rd_addr = idx_addr;
            default:             rd_addr = pos_addr;
        endcase

        case (ctrl.wa_sel)
            ilt_pkg::WA_COUNT:   wr_addr = count_reg[AW-1:0];
            ilt_pkg::WA_IDX:     wr_addr = idx_addr;
            ilt_pkg::WA_IDX_DEC: wr_addr = idx_dec_addr;
            default:             wr_addr = pos_addr;
        endcase

        case (ctrl.wd_sel)
            ilt_pkg::WD_RDATA: wr_data = rdata_reg;
            ilt_pkg::WD_ZERO:  wr_data = '0;
            default:           wr_data = word_reg;
        endcase

        case (ctrl.idx_op)
            ilt_pkg::IDX_LD_COUNT: idx_next = count_reg;
            ilt_pkg::IDX_LD_POS:   idx_next = CW'(pos_reg);
            ilt_pkg::IDX_INC:      idx_next = idx_reg + CW'(1);
            ilt_pkg::IDX_DEC:      idx_next = idx_reg - CW'(1);
            default:               idx_next = idx_reg;
        endcase

        case (ctrl.cnt_op)
            ilt_pkg::CNT_INC:       count_next = count_reg + CW'(1);
            ilt_pkg::CNT_DEC:       count_next = count_reg - CW'(1);
            ilt_pkg::CNT_LD_TARGET: count_next = CW'(target_reg);
            default:                count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg    <= cmd;
            pos_reg    <= position;
            word_reg   <= word;
            target_reg <= new_count;
        end
        idx_reg <= idx_next;
        if (ctrl.fin)
        begin
            status_reg    <= ctrl.fin_status;
            read_word_reg <= ctrl.take_rdata ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= ctrl.fin;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign read_word = read_word_reg;
    assign count     = ilt_pkg::COUNT_W'(count_reg);

    `ILT_ASSERT_NEXT(a_done_single, done_reg, !done_reg,
        "Result strobe held for more than one cycle.")
    `ILT_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY),
        "Entry count exceeds the store capacity.")
    `ILT_ASSERT(a_wr_in_range, ctrl.we |-> (EW'(wr_addr) < EW'(CAPACITY)),
        "Store write outside the entry range.")

endmodule
